// ===== rtl/core/fba_pkg.sv =====
package fba_pkg;

   localparam int NUM_BLOCKS = 16;
   localparam int SIZE_WIDTH = 16;
   localparam int IDX_W      = $clog2(NUM_BLOCKS);
   localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
   localparam int CSR_W      = 5;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_ALLOC = 1'b1;

   localparam logic CSR_FIT_MODE      = 1'b0;
   localparam logic CSR_BLOCKS_IN_USE = 1'b1;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(NUM_BLOCKS);

   typedef enum logic [1:0] {
      FIT_BEST  = 2'd0,
      FIT_WORST = 2'd1,
      FIT_FIRST = 2'd2,
      FIT_NEXT  = 2'd3
   } fit_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  kind;
      logic [IDX_W-1:0]      load_index;
      logic [SIZE_WIDTH-1:0] block_capacity;
      logic [SIZE_WIDTH-1:0] request_size;
   } req_type;

   typedef struct packed {
      logic             granted;
      logic [IDX_W-1:0] chosen_block;
   } rsp_type;

   // one access to the capacity table
   typedef struct packed {
      logic                  rd_en;
      logic [IDX_W-1:0]      rd_addr;
      logic                  wr_en;
      logic [IDX_W-1:0]      wr_addr;
      logic [SIZE_WIDTH-1:0] wr_data;
   } tbl_port_type;

   typedef struct packed {
      logic                  valid;
      logic [SIZE_WIDTH-1:0] size;
      fit_mode_type          mode;
      logic [CNT_W-1:0]      count;
   } start_type;

   typedef struct packed {
      logic             done;
      logic             granted;
      logic [IDX_W-1:0] chosen;
   } result_type;

endpackage

// ===== rtl/core/fba_table.sv =====
module fba_table (
   input  logic                             clock,
   input  fba_pkg::tbl_port_type            port,
   output logic [fba_pkg::SIZE_WIDTH-1:0]   rd_data
);

   logic [fba_pkg::SIZE_WIDTH-1:0] mem [fba_pkg::NUM_BLOCKS];
   logic [fba_pkg::SIZE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         mem[port.wr_addr] <= port.wr_data;
      end
      if (port.rd_en) begin
         rd_data_ff <= mem[port.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/fba_seq.sv =====
module fba_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  fba_pkg::start_type               start,
   input  logic                             out_free,
   input  logic [fba_pkg::SIZE_WIDTH-1:0]   rd_data,
   output fba_pkg::tbl_port_type            port,
   output fba_pkg::result_type              result,
   output logic                             idle
);

   fba_pkg::state_type              state_ff, state_in;
   logic [fba_pkg::SIZE_WIDTH-1:0]  size_ff, size_in;
   fba_pkg::fit_mode_type           mode_ff, mode_in;
   logic [fba_pkg::CNT_W-1:0]       lim_ff, lim_in;
   logic [fba_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [fba_pkg::IDX_W-1:0]       addr_ff, addr_in;
   logic [fba_pkg::IDX_W-1:0]       ptr_ff, ptr_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic [fba_pkg::IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                            found_ff, found_in;
   logic [fba_pkg::IDX_W-1:0]       pick_ff, pick_in;
   logic [fba_pkg::SIZE_WIDTH-1:0]  pick_cap_ff, pick_cap_in;

   logic                            cap_ok;
   logic                            better;
   logic                            stop_first;
   logic [fba_pkg::CNT_W-1:0]       addr_inc;

   // shared compare unit
   assign cap_ok = (rd_data >= size_ff);
   assign better = ((mode_ff == fba_pkg::FIT_BEST)  && (rd_data < pick_cap_ff)) ||
                   ((mode_ff == fba_pkg::FIT_WORST) && (rd_data > pick_cap_ff));
   assign stop_first = mode_ff inside {fba_pkg::FIT_FIRST, fba_pkg::FIT_NEXT};
   assign addr_inc = {1'b0, addr_ff} + fba_pkg::CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fba_pkg::ST_IDLE: begin
            if (start.valid) begin
               state_in = (start.count == '0) ? fba_pkg::ST_DONE : fba_pkg::ST_SCAN;
            end
         end
         fba_pkg::ST_SCAN: begin
            if (rd_vld_ff && cap_ok && stop_first) begin
               state_in = fba_pkg::ST_WRITE;
            end else if (!rd_vld_ff && (cnt_ff == lim_ff)) begin
               state_in = found_ff ? fba_pkg::ST_WRITE : fba_pkg::ST_DONE;
            end
         end
         fba_pkg::ST_WRITE: begin
            state_in = fba_pkg::ST_DONE;
         end
         fba_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = fba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fba_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      size_in     = size_ff;
      mode_in     = mode_ff;
      lim_in      = lim_ff;
      cnt_in      = cnt_ff;
      addr_in     = addr_ff;
      ptr_in      = ptr_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      found_in    = found_ff;
      pick_in     = pick_ff;
      pick_cap_in = pick_cap_ff;
      port        = '0;
      result      = '0;
      idle        = 1'b0;
      case (state_ff)
         fba_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (start.valid) begin
               size_in  = start.size;
               mode_in  = start.mode;
               lim_in   = start.count;
               cnt_in   = '0;
               found_in = 1'b0;
               pick_in  = '0;
               // next fit resumes at the stored pointer when it is still in range
               if ((start.mode == fba_pkg::FIT_NEXT) && ({1'b0, ptr_ff} < start.count)) begin
                  addr_in = ptr_ff;
               end else begin
                  addr_in = '0;
               end
            end
         end
         fba_pkg::ST_SCAN: begin
            if (cnt_ff < lim_ff) begin
               port.rd_en   = 1'b1;
               port.rd_addr = addr_ff;
               rd_idx_in    = addr_ff;
               rd_vld_in    = 1'b1;
               cnt_in       = cnt_ff + fba_pkg::CNT_W'(1);
               addr_in      = (addr_inc == lim_ff) ? '0 : addr_inc[fba_pkg::IDX_W-1:0];
            end
            if (rd_vld_ff && cap_ok && (!found_ff || better)) begin
               found_in    = 1'b1;
               pick_in     = rd_idx_ff;
               pick_cap_in = rd_data;
            end
         end
         fba_pkg::ST_WRITE: begin
            port.wr_en   = 1'b1;
            port.wr_addr = pick_ff;
            port.wr_data = pick_cap_ff - size_ff;
            if (mode_ff == fba_pkg::FIT_NEXT) begin
               ptr_in = pick_ff;
            end
         end
         fba_pkg::ST_DONE: begin
            result.done    = 1'b1;
            result.granted = found_ff;
            result.chosen  = found_ff ? pick_ff : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fba_pkg::ST_IDLE;
         ptr_ff    <= '0;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         rd_vld_ff <= rd_vld_in;
         found_ff  <= found_in;
      end
      size_ff     <= size_in;
      mode_ff     <= mode_in;
      lim_ff      <= lim_in;
      cnt_ff      <= cnt_in;
      addr_ff     <= addr_in;
      rd_idx_ff   <= rd_idx_in;
      pick_ff     <= pick_in;
      pick_cap_ff <= pick_cap_in;
   end

endmodule

// ===== rtl/core/fit_block_allocator_core.sv =====
// Memory block allocator with first, best, worst and next fit policies.
// Request channel (req_valid/req_stall/req_data): kind 0 loads block_capacity
// into block load_index with no response; kind 1 asks for request_size and
// yields exactly one response on rsp_valid/rsp_data.
// An allocation is answered with no table walk when no blocks are in use;
// otherwise one compare unit walks the capacity table one block per cycle,
// followed by a write-back and a hand-off; a refused request skips the
// write-back. First and next fit stop at the first block that fits.
// req_stall is high until the response is handed off, and the next request
// can be taken in the cycle after, so a new allocation is not accepted before
// the last one is through, while loads run one per cycle whenever no
// allocation is in progress.
// Configuration (csr_write_enable/csr_index/csr_write_data): index 0 is
// fit_mode, index 1 is blocks_in_use (values above 16 act as 16); write
// only while the block is idle.
// Reset (synchronous, active high) selects best fit, 16 blocks and a next-fit
// pointer of 0; capacities must be loaded before they are allocated.
// A response waits in the output register while rsp_stall is high; the
// sequencer holds its finished result until that register frees up.
module fit_block_allocator_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  fba_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output fba_pkg::rsp_type           rsp_data,
   input  logic                       csr_write_enable,
   input  logic                       csr_index,
   input  logic [fba_pkg::CSR_W-1:0]  csr_write_data
);

   fba_pkg::fit_mode_type           mode_ff, mode_in;
   logic [fba_pkg::CSR_W-1:0]       in_use_ff, in_use_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   fba_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                            req_accept;
   logic                            seq_idle;
   logic                            out_free;
   logic [fba_pkg::CNT_W-1:0]       count;
   fba_pkg::start_type              start;
   fba_pkg::result_type             result;
   fba_pkg::tbl_port_type           seq_port;
   fba_pkg::tbl_port_type           tbl_port;
   logic [fba_pkg::SIZE_WIDTH-1:0]  rd_data;

   assign req_stall  = !seq_idle;
   assign req_accept = req_valid && seq_idle;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign count = (in_use_ff > fba_pkg::CSR_W'(fba_pkg::NUM_BLOCKS)) ?
                  fba_pkg::MAX_COUNT : fba_pkg::CNT_W'(in_use_ff);

   always_comb begin
      start       = '0;
      start.valid = req_accept && (req_data.kind == fba_pkg::KIND_ALLOC);
      start.size  = req_data.request_size;
      start.mode  = mode_ff;
      start.count = count;
   end

   // loads only arrive while the sequencer is idle, so the ports never collide
   always_comb begin
      tbl_port = seq_port;
      if (req_accept && (req_data.kind == fba_pkg::KIND_LOAD)) begin
         tbl_port.wr_en   = 1'b1;
         tbl_port.wr_addr = req_data.load_index;
         tbl_port.wr_data = req_data.block_capacity;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      in_use_in = in_use_ff;
      if (csr_write_enable) begin
         case (csr_index)
            fba_pkg::CSR_FIT_MODE: begin
               mode_in = fba_pkg::fit_mode_type'(csr_write_data[1:0]);
            end
            fba_pkg::CSR_BLOCKS_IN_USE: begin
               in_use_in = csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result.done && out_free) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.granted      = result.granted;
         rsp_data_in.chosen_block = result.chosen;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= fba_pkg::FIT_BEST;
         in_use_ff    <= fba_pkg::CSR_W'(fba_pkg::NUM_BLOCKS);
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   fba_table u_table (
      .clock   (clock),
      .port    (tbl_port),
      .rd_data (rd_data)
   );

   fba_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .rd_data  (rd_data),
      .port     (seq_port),
      .result   (result),
      .idle     (seq_idle)
   );

endmodule
